### sv/lbfr_pkg.sv
// Shared constants, types and CORDIC tables for the lidar beam reprojection block.
// Used by every module of the block; depends on nothing.
package lbfr_pkg;

  localparam int SCAN_BEAMS_DEF = 1024;

  // Angles in units of 2^-14 rad.
  localparam int PI_U       = 51472;
  localparam int HALF_PI_U  = 25736;
  localparam int TWO_PI_U   = 102944;
  localparam int THREE_PI_U = 154416;
  localparam int GAIN_Q14   = 9949;
  localparam int ITERS      = 15;

  // Field widths.
  localparam int IDX_W   = 10;
  localparam int RNG_W   = 16;
  localparam int AMIN_W  = 17;
  localparam int STEP_W  = 15;
  localparam int ROT_W   = 16;
  localparam int SHIFT_W = 16;
  localparam int CFG_W   = 17;

  // Internal widths.
  localparam int RED_W   = 26;  // beam angle offset by 3*pi, always positive
  localparam int RECIP_SH = 40;
  localparam logic [23:0] RECIP = 24'((64'd1 << RECIP_SH) / 64'd102944);
  localparam int MUL_W   = 50;
  localparam int Z_W     = 18;  // CORDIC angle accumulator
  localparam int CS_W    = 18;  // cos/sin in Q14
  localparam int PX_W    = 32;  // range * cos
  localparam int P_W     = 48;  // rotation products
  localparam int B_W     = 34;  // transformed point, Q14 mm
  localparam int VW      = 36;  // vectoring datapath
  localparam int D_W     = 20;  // bearing difference
  localparam int NUM_W   = 19;  // magnitude of the bearing difference

  localparam logic signed [Z_W-1:0] ATAN_TAB [ITERS] = '{
    18'sd12868, 18'sd7596, 18'sd4014, 18'sd2037, 18'sd1023, 18'sd512, 18'sd256,
    18'sd128, 18'sd64, 18'sd32, 18'sd16, 18'sd8, 18'sd4, 18'sd2, 18'sd1
  };

  typedef enum logic [2:0] {
    CFG_IN_ANGLE_MIN = 3'd0,
    CFG_ANGLE_STEP   = 3'd1,
    CFG_ROT_XX       = 3'd2,
    CFG_ROT_XY       = 3'd3,
    CFG_ROT_YX       = 3'd4,
    CFG_ROT_YY       = 3'd5,
    CFG_SHIFT_X      = 3'd6,
    CFG_SHIFT_Y      = 3'd7
  } cfg_reg_e;

endpackage

### sv/lbfr_rotate.sv
// Rotation-mode CORDIC pipeline: reduced angle in, cos/sin (Q14) out.
// One quadrant-fold stage then one register stage per iteration. Uses lbfr_pkg.
module lbfr_rotate #(
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [lbfr_pkg::Z_W-1:0]   ang_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic signed [lbfr_pkg::CS_W-1:0]  cos_o,
  output logic signed [lbfr_pkg::CS_W-1:0]  sin_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int N = lbfr_pkg::ITERS;

  logic                              valid_q [N+1];
  logic signed [lbfr_pkg::CS_W-1:0]  x_q [N+1];
  logic signed [lbfr_pkg::CS_W-1:0]  y_q [N+1];
  logic signed [lbfr_pkg::Z_W-1:0]   z_q [N+1];
  logic                              neg_q [N+1];
  logic [SIDE_W-1:0]                 side_q [N+1];

  logic signed [lbfr_pkg::Z_W-1:0]   z0_d;
  logic                              neg0_d;

  // fold into [-pi/2, pi/2], negate the result later
  always_comb begin
    z0_d   = ang_i;
    neg0_d = 1'b0;
    if (ang_i > lbfr_pkg::Z_W'(lbfr_pkg::HALF_PI_U)) begin
      z0_d   = ang_i - lbfr_pkg::Z_W'(lbfr_pkg::PI_U);
      neg0_d = 1'b1;
    end else if (ang_i < -lbfr_pkg::Z_W'(lbfr_pkg::HALF_PI_U)) begin
      z0_d   = ang_i + lbfr_pkg::Z_W'(lbfr_pkg::PI_U);
      neg0_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= lbfr_pkg::CS_W'(lbfr_pkg::GAIN_Q14);
      y_q[0]    <= '0;
      z_q[0]    <= z0_d;
      neg_q[0]  <= neg0_d;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - lbfr_pkg::ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + lbfr_pkg::ATAN_TAB[i];
        end
        neg_q[i+1]  <= neg_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = valid_q[N];
  assign cos_o   = neg_q[N] ? -x_q[N] : x_q[N];
  assign sin_o   = neg_q[N] ? -y_q[N] : y_q[N];
  assign side_o  = side_q[N];

endmodule

### sv/lbfr_vector.sv
// Vectoring-mode CORDIC pipeline: (x, y) in, bearing and scaled magnitude out.
// One half-plane stage then one register stage per iteration. Uses lbfr_pkg.
module lbfr_vector #(
  parameter int W      = lbfr_pkg::VW,
  parameter int SIDE_W = 1
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic signed [W-1:0]              x_i,
  input  logic signed [W-1:0]              y_i,
  input  logic [SIDE_W-1:0]                side_i,
  output logic                             valid_o,
  output logic signed [lbfr_pkg::Z_W-1:0]  ang_o,
  output logic signed [W-1:0]              mag_o,
  output logic [SIDE_W-1:0]                side_o
);

  localparam int N = lbfr_pkg::ITERS;

  logic                             valid_q [N+1];
  logic signed [W-1:0]              x_q [N+1];
  logic signed [W-1:0]              y_q [N+1];
  logic signed [lbfr_pkg::Z_W-1:0]  z_q [N+1];
  logic [SIDE_W-1:0]                side_q [N+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  // left half plane: mirror through the origin and start from +/-pi
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (x_i < 0) begin
        x_q[0] <= -x_i;
        y_q[0] <= -y_i;
        z_q[0] <= (y_i >= 0) ? lbfr_pkg::Z_W'(lbfr_pkg::PI_U)
                             : -lbfr_pkg::Z_W'(lbfr_pkg::PI_U);
      end else begin
        x_q[0] <= x_i;
        y_q[0] <= y_i;
        z_q[0] <= '0;
      end
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + lbfr_pkg::ATAN_TAB[i];
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - lbfr_pkg::ATAN_TAB[i];
        end
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = valid_q[N];
  assign ang_o   = z_q[N];
  assign mag_o   = x_q[N];
  assign side_o  = side_q[N];

endmodule

### sv/lbfr_divide.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag
// for quotients at or above 2^QB. Uses lbfr_pkg for widths.
module lbfr_divide #(
  parameter int QB     = 10,
  parameter int SIDE_W = 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic [lbfr_pkg::NUM_W-1:0]        num_i,
  input  logic [lbfr_pkg::STEP_W-1:0]       den_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [QB-1:0]                     quo_o,
  output logic                              ovf_o,
  output logic [SIDE_W-1:0]                 side_o
);

  localparam int CW = lbfr_pkg::NUM_W + lbfr_pkg::STEP_W + QB;

  logic              valid_q [QB+1];
  logic [CW-1:0]     rem_q [QB+1];
  logic [QB-1:0]     quo_q [QB+1];
  logic              ovf_q [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CW'(num_i);
      quo_q[0]  <= '0;
      ovf_q[0]  <= CW'(num_i) >= (CW'(den_i) << QB);
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_bit
    localparam int K = QB - 1 - j;
    logic [CW-1:0] trial;
    assign trial = CW'(den_i) << K;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[j+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[j+1] <= valid_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1] <= quo_q[j];
        if (rem_q[j] >= trial) begin
          rem_q[j+1]    <= rem_q[j] - trial;
          quo_q[j+1][K] <= 1'b1;
        end else begin
          rem_q[j+1] <= rem_q[j];
        end
        ovf_q[j+1]  <= ovf_q[j];
        side_q[j+1] <= side_q[j];
      end
    end
  end

  assign valid_o = valid_q[QB];
  assign quo_o   = quo_q[QB];
  assign ovf_o   = ovf_q[QB];
  assign side_o  = side_q[QB];

endmodule

### sv/lidar_beam_frame_reprojection.sv
// Top level of the lidar beam reprojection pipeline.
// Depends on lbfr_pkg, lbfr_rotate, lbfr_vector and lbfr_divide.
//
// Reprojects one lidar beam per clock into another frame. A beam (index, range
// in mm, finite flag) enters as one beat; its angle in_angle_min + index *
// angle_step is wrapped into [-pi, pi) with a reciprocal multiply, turned into
// cos/sin by a rotation CORDIC, scaled by the range, rotated and shifted by the
// configured 2x2 Q1.14 matrix and mm offset, then turned back into range and
// bearing by a vectoring CORDIC. The output bin is (bearing - in_angle_min -
// yaw) / angle_step truncated toward zero, from a one-bit-per-stage divider;
// yaw = atan2(rot_yx, rot_xx) comes from a second, free-running vectoring
// CORDIC fed straight from the registers; it settles after any write well
// before a beam accepted right after the write reaches the bin stage.
// Range saturates at 65535; beams not finite or with index >= SCAN_BEAMS give
// hit 0, bin 0 and range 65535. Throughput is one beat per cycle while the
// skid register is empty; the path runs through two 16-stage CORDIC pipelines
// and the divider. An output register plus a skid register let the input keep
// flowing while a result waits; the pipeline only stalls when the skid register
// is full. Angles are in 2^-14 rad.
module lidar_beam_frame_reprojection #(
  parameter int SCAN_BEAMS = lbfr_pkg::SCAN_BEAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // beam input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [9:0] beam_index, [25:10] beam_range
  input  logic        s_axis_tuser,   // [0] range_finite
  // result output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [9:0] out_index, [25:10] out_range
  output logic        m_axis_tuser,   // [0] hit
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i
);

  localparam int QB = $clog2(SCAN_BEAMS);

  typedef struct packed {
    logic                          kill;
    logic [lbfr_pkg::RNG_W-1:0]    range;
  } rot_side_t;

  typedef struct packed {
    logic                          kill;
    logic                          dneg;
    logic [lbfr_pkg::RNG_W-1:0]    dist_mm;
  } div_side_t;

  typedef struct packed {
    logic [lbfr_pkg::RNG_W-1:0]    range;
    logic [lbfr_pkg::IDX_W-1:0]    index;
    logic                          hit;
  } result_t;

  // ---------------------------------------------------------------- config
  logic signed [lbfr_pkg::AMIN_W-1:0]  cfg_amin_q;
  logic [lbfr_pkg::STEP_W-1:0]         cfg_step_q;
  logic signed [lbfr_pkg::ROT_W-1:0]   cfg_rxx_q, cfg_rxy_q, cfg_ryx_q, cfg_ryy_q;
  logic signed [lbfr_pkg::SHIFT_W-1:0] cfg_tx_q, cfg_ty_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_amin_q <= '0;
      cfg_step_q <= lbfr_pkg::STEP_W'(103);
      cfg_rxx_q  <= lbfr_pkg::ROT_W'(16384);
      cfg_rxy_q  <= '0;
      cfg_ryx_q  <= '0;
      cfg_ryy_q  <= lbfr_pkg::ROT_W'(16384);
      cfg_tx_q   <= '0;
      cfg_ty_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (lbfr_pkg::cfg_reg_e'(cfg_index_i))
        lbfr_pkg::CFG_IN_ANGLE_MIN: cfg_amin_q <= cfg_data_i;
        lbfr_pkg::CFG_ANGLE_STEP:   cfg_step_q <= cfg_data_i[lbfr_pkg::STEP_W-1:0];
        lbfr_pkg::CFG_ROT_XX:       cfg_rxx_q  <= cfg_data_i[lbfr_pkg::ROT_W-1:0];
        lbfr_pkg::CFG_ROT_XY:       cfg_rxy_q  <= cfg_data_i[lbfr_pkg::ROT_W-1:0];
        lbfr_pkg::CFG_ROT_YX:       cfg_ryx_q  <= cfg_data_i[lbfr_pkg::ROT_W-1:0];
        lbfr_pkg::CFG_ROT_YY:       cfg_ryy_q  <= cfg_data_i[lbfr_pkg::ROT_W-1:0];
        lbfr_pkg::CFG_SHIFT_X:      cfg_tx_q   <= cfg_data_i[lbfr_pkg::SHIFT_W-1:0];
        lbfr_pkg::CFG_SHIFT_Y:      cfg_ty_q   <= cfg_data_i[lbfr_pkg::SHIFT_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------- flow
  // Whole pipeline advances together; only a full skid register stops it.
  logic en;
  logic out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res_d;

  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  // ---------------------------------------------------------------- yaw
  logic signed [lbfr_pkg::Z_W-1:0] yaw;
  logic signed [lbfr_pkg::VW-1:0]  yaw_mag;
  logic                            yaw_valid;
  logic                            yaw_side;

  lbfr_vector #(.W(lbfr_pkg::VW), .SIDE_W(1)) u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (1'b1),
    .valid_i (1'b1),
    .x_i     (lbfr_pkg::VW'(cfg_rxx_q)),
    .y_i     (lbfr_pkg::VW'(cfg_ryx_q)),
    .side_i  (1'b0),
    .valid_o (yaw_valid),
    .ang_o   (yaw),
    .mag_o   (yaw_mag),
    .side_o  (yaw_side)
  );

  // ---------------------------------------------------------------- stage A
  // beam angle, offset by 3*pi so it is positive and wraps like +pi
  logic                         a_valid_q, a_kill_q;
  logic [lbfr_pkg::RNG_W-1:0]   a_range_q;
  logic [lbfr_pkg::RED_W-1:0]   a_ang_q;
  logic [lbfr_pkg::IDX_W-1:0]   in_idx;

  assign in_idx = s_axis_tdata[9:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_kill_q  <= !s_axis_tuser || (32'(in_idx) >= 32'(SCAN_BEAMS));
      a_range_q <= s_axis_tdata[25:10];
      a_ang_q   <= lbfr_pkg::RED_W'(27'(cfg_amin_q) + 27'(in_idx) * 27'(cfg_step_q)
                                    + 27'(lbfr_pkg::THREE_PI_U));
    end
  end

  // ---------------------------------------------------------------- stage B
  logic                         b_valid_q, b_kill_q;
  logic [lbfr_pkg::RNG_W-1:0]   b_range_q;
  logic [lbfr_pkg::RED_W-1:0]   b_ang_q;
  logic [lbfr_pkg::MUL_W-1:0]   b_prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (en) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_kill_q  <= a_kill_q;
      b_range_q <= a_range_q;
      b_ang_q   <= a_ang_q;
      b_prod_q  <= lbfr_pkg::MUL_W'(a_ang_q) * lbfr_pkg::MUL_W'(lbfr_pkg::RECIP);
    end
  end

  // ---------------------------------------------------------------- stage C
  // estimated quotient is exact or one short: one correcting subtract
  logic                         c_valid_q;
  rot_side_t                    c_side_q;
  logic signed [lbfr_pkg::Z_W-1:0] c_red_q;
  logic [9:0]                   b_quo;
  logic [26:0]                  b_diff;
  logic [17:0]                  b_rem0, b_rem;

  assign b_quo  = b_prod_q[lbfr_pkg::RECIP_SH +: 10];
  assign b_diff = 27'(b_ang_q) - 27'(b_quo) * 27'(lbfr_pkg::TWO_PI_U);
  assign b_rem0 = b_diff[17:0];
  assign b_rem  = (b_rem0 >= 18'(lbfr_pkg::TWO_PI_U)) ? b_rem0 - 18'(lbfr_pkg::TWO_PI_U)
                                                      : b_rem0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_side_q.kill  <= b_kill_q;
      c_side_q.range <= b_range_q;
      c_red_q        <= lbfr_pkg::Z_W'(b_rem) - lbfr_pkg::Z_W'(lbfr_pkg::PI_U);
    end
  end

  // ---------------------------------------------------------------- rotation
  logic                             r_valid;
  logic signed [lbfr_pkg::CS_W-1:0] r_cos, r_sin;
  rot_side_t                        r_side;

  lbfr_rotate #(.SIDE_W($bits(rot_side_t))) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (c_valid_q),
    .ang_i   (c_red_q),
    .side_i  (c_side_q),
    .valid_o (r_valid),
    .cos_o   (r_cos),
    .sin_o   (r_sin),
    .side_o  (r_side)
  );

  // ---------------------------------------------------------------- stage D
  logic                              d_valid_q, d_kill_q;
  logic signed [lbfr_pkg::PX_W-1:0]  d_px_q, d_py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (en) begin
      d_valid_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_kill_q <= r_side.kill;
      d_px_q   <= lbfr_pkg::PX_W'(signed'({1'b0, r_side.range})) * lbfr_pkg::PX_W'(r_cos);
      d_py_q   <= lbfr_pkg::PX_W'(signed'({1'b0, r_side.range})) * lbfr_pkg::PX_W'(r_sin);
    end
  end

  // ---------------------------------------------------------------- stage E
  logic                              e_valid_q, e_kill_q;
  logic signed [lbfr_pkg::P_W-1:0]   e_xx_q, e_xy_q, e_yx_q, e_yy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (en) begin
      e_valid_q <= d_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_kill_q <= d_kill_q;
      e_xx_q   <= lbfr_pkg::P_W'(cfg_rxx_q) * lbfr_pkg::P_W'(d_px_q);
      e_xy_q   <= lbfr_pkg::P_W'(cfg_rxy_q) * lbfr_pkg::P_W'(d_py_q);
      e_yx_q   <= lbfr_pkg::P_W'(cfg_ryx_q) * lbfr_pkg::P_W'(d_px_q);
      e_yy_q   <= lbfr_pkg::P_W'(cfg_ryy_q) * lbfr_pkg::P_W'(d_py_q);
    end
  end

  // ---------------------------------------------------------------- stage F
  // point in Q14 mm: floor of the rotated sum, plus the offset
  logic                              f_valid_q, f_kill_q;
  logic signed [lbfr_pkg::B_W-1:0]   f_bx_q, f_by_q;
  logic signed [lbfr_pkg::P_W-1:0]   e_sx, e_sy;

  assign e_sx = e_xx_q + e_xy_q;
  assign e_sy = e_yx_q + e_yy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= e_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_kill_q <= e_kill_q;
      f_bx_q   <= lbfr_pkg::B_W'(e_sx >>> 14) + (lbfr_pkg::B_W'(cfg_tx_q) <<< 14);
      f_by_q   <= lbfr_pkg::B_W'(e_sy >>> 14) + (lbfr_pkg::B_W'(cfg_ty_q) <<< 14);
    end
  end

  // ---------------------------------------------------------------- vectoring
  logic                             v_valid;
  logic signed [lbfr_pkg::Z_W-1:0]  v_bear;
  logic signed [lbfr_pkg::VW-1:0]   v_mag;
  logic                             v_kill;

  lbfr_vector #(.W(lbfr_pkg::VW), .SIDE_W(1)) u_vector (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid_q),
    .x_i     (lbfr_pkg::VW'(f_bx_q)),
    .y_i     (lbfr_pkg::VW'(f_by_q)),
    .side_i  (f_kill_q),
    .valid_o (v_valid),
    .ang_o   (v_bear),
    .mag_o   (v_mag),
    .side_o  (v_kill)
  );

  // ---------------------------------------------------------------- stage G
  // bearing relative to the output start; magnitude gain split in two halves
  logic                             g_valid_q, g_kill_q;
  logic signed [lbfr_pkg::D_W-1:0]  g_diff_q;
  logic [31:0]                      g_plo_q, g_phi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_valid_q <= 1'b0;
    end else if (en) begin
      g_valid_q <= v_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_kill_q <= v_kill;
      g_diff_q <= lbfr_pkg::D_W'(v_bear) - lbfr_pkg::D_W'(cfg_amin_q) - lbfr_pkg::D_W'(yaw);
      g_plo_q  <= 32'(v_mag[17:0]) * 32'(lbfr_pkg::GAIN_Q14);
      g_phi_q  <= 32'(v_mag[35:18]) * 32'(lbfr_pkg::GAIN_Q14);
    end
  end

  // ---------------------------------------------------------------- stage H
  logic                             h_valid_q;
  div_side_t                        h_side_q;
  logic [lbfr_pkg::NUM_W-1:0]       h_num_q;
  logic [51:0]                      g_sum;
  logic signed [lbfr_pkg::D_W-1:0]  g_neg;

  assign g_sum = (52'(g_phi_q) << 18) + 52'(g_plo_q) + (52'd1 << 27);
  assign g_neg = -g_diff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_valid_q <= 1'b0;
    end else if (en) begin
      h_valid_q <= g_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_side_q.kill    <= g_kill_q;
      h_side_q.dneg    <= g_diff_q[lbfr_pkg::D_W-1];
      h_side_q.dist_mm <= (g_sum[51:44] != '0) ? '1 : g_sum[43:28];
      h_num_q          <= g_diff_q[lbfr_pkg::D_W-1] ? g_neg[lbfr_pkg::NUM_W-1:0]
                                                    : g_diff_q[lbfr_pkg::NUM_W-1:0];
    end
  end

  // ---------------------------------------------------------------- bin
  logic        q_valid, q_ovf;
  logic [QB-1:0] q_quo;
  div_side_t   q_side;
  logic [31:0] q_wide;
  logic        q_inside;

  lbfr_divide #(.QB(QB), .SIDE_W($bits(div_side_t))) u_divide (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h_valid_q),
    .num_i   (h_num_q),
    .den_i   (cfg_step_q),
    .side_i  (h_side_q),
    .valid_o (q_valid),
    .quo_o   (q_quo),
    .ovf_o   (q_ovf),
    .side_o  (q_side)
  );

  // truncation toward zero: a negative difference only lands in bin 0
  assign q_wide   = 32'(q_quo);
  assign q_inside = q_side.dneg ? (q_wide == '0) : (q_wide < 32'(SCAN_BEAMS));

  always_comb begin
    res_d.hit   = !q_side.kill && (cfg_step_q != '0) && !q_ovf && q_inside;
    res_d.index = res_d.hit ? q_wide[lbfr_pkg::IDX_W-1:0] : '0;
    res_d.range = q_side.kill ? '1 : q_side.dist_mm;
  end

  // ---------------------------------------------------------------- output + skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (m_axis_tready || !out_valid_q) begin
      out_valid_q  <= skid_valid_q || (en && q_valid);
      skid_valid_q <= 1'b0;
    end else if (en && q_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_valid_q) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (en && q_valid) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.range, out_q.index};
  assign m_axis_tuser  = out_q.hit;

  // ---------------------------------------------------------------- checks
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a beat while the output register is empty");

  a_skid_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !m_axis_tready))
    else $error("skid register filled while the output was free");

  a_miss_bin_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[9:0] == '0))
    else $error("missed beam carries a nonzero bin");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |=> $stable(a_valid_q))
    else $error("pipeline moved while the skid register was full");

endmodule

### tb/tb_lidar_beam_frame_reprojection.sv
// Testbench for lidar_beam_frame_reprojection: stream beams in, check reprojected results.
// Depends on lbfr_pkg and the block RTL; holds its own fixed-point CORDIC predictor.
module tb_lidar_beam_frame_reprojection;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBEAMS = 1024;
  localparam longint PI_L = 51472;
  localparam longint HPI_L = 25736;
  localparam longint TPI_L = 102944;
  localparam longint GAIN_L = 9949;
  localparam longint ARC_TAB [15] = '{12868, 7596, 4014, 2037, 1023, 512, 256, 128,
                                      64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic [9:0]  bin;
    logic [15:0] dist_mm;
    logic        hit;
  } reproj_t;

  // floor shift
  function automatic longint fshr(longint v, int s);
    return v >>> s;
  endfunction

  // angle -> cos/sin in Q14 (rotation CORDIC)
  function automatic void beam_trig(longint ang, output longint c, output longint s);
    longint m, x, y, t;
    bit flip;
    m = ang % TPI_L;
    x = GAIN_L;
    y = 0;
    flip = 0;
    if (m < 0) m += TPI_L;
    if (m >= PI_L) m -= TPI_L;
    if (m > HPI_L) begin
      m -= PI_L; flip = 1;
    end else if (m < -HPI_L) begin
      m += PI_L; flip = 1;
    end
    for (int i = 0; i < 15; i++) begin
      if (m >= 0) begin
        t = x - fshr(y, i); y = y + fshr(x, i); m -= ARC_TAB[i];
      end else begin
        t = x + fshr(y, i); y = y - fshr(x, i); m += ARC_TAB[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // vector -> bearing and unscaled magnitude
  function automatic void bearing_of(longint x, longint y, output longint z, output longint mag);
    longint t;
    z = 0;
    if (x < 0) begin
      z = (y >= 0) ? PI_L : -PI_L;
      x = -x; y = -y;
    end
    for (int i = 0; i < 15; i++) begin
      if (y >= 0) begin
        t = x + fshr(y, i); y = y - fshr(x, i); z += ARC_TAB[i];
      end else begin
        t = x - fshr(y, i); y = y + fshr(x, i); z -= ARC_TAB[i];
      end
      x = t;
    end
    mag = x;
  endfunction

  class reproj_board;
    logic [16:0] regs [8];
    reproj_t pending[$];
    int errors;

    function new();
      errors = 0;
      regs[lbfr_pkg::CFG_IN_ANGLE_MIN] = 0;
      regs[lbfr_pkg::CFG_ANGLE_STEP]   = 103;
      regs[lbfr_pkg::CFG_ROT_XX]       = 16384;
      regs[lbfr_pkg::CFG_ROT_XY]       = 0;
      regs[lbfr_pkg::CFG_ROT_YX]       = 0;
      regs[lbfr_pkg::CFG_ROT_YY]       = 16384;
      regs[lbfr_pkg::CFG_SHIFT_X]      = 0;
      regs[lbfr_pkg::CFG_SHIFT_Y]      = 0;
    endfunction

    function void write_reg(lbfr_pkg::cfg_reg_e idx, logic [16:0] v);
      regs[idx] = (idx == lbfr_pkg::CFG_IN_ANGLE_MIN) ? v :
                  (idx == lbfr_pkg::CFG_ANGLE_STEP) ? {2'b0, v[14:0]} : {1'b0, v[15:0]};
    endfunction

    function void note_beam(logic [9:0] idx, logic [15:0] rng, logic fin);
      reproj_t e;
      longint amin, step, rxx, rxy, ryx, ryy, tx, ty, c, s, px, py, bx, by;
      longint bear, mag, yaw, ymag, dmm, q;
      e = '{bin: 0, dist_mm: 16'hFFFF, hit: 0};
      if (fin && idx < NBEAMS) begin
        amin = longint'(signed'(regs[lbfr_pkg::CFG_IN_ANGLE_MIN]));
        step = longint'(regs[lbfr_pkg::CFG_ANGLE_STEP][14:0]);
        rxx = longint'(signed'(regs[lbfr_pkg::CFG_ROT_XX][15:0]));
        rxy = longint'(signed'(regs[lbfr_pkg::CFG_ROT_XY][15:0]));
        ryx = longint'(signed'(regs[lbfr_pkg::CFG_ROT_YX][15:0]));
        ryy = longint'(signed'(regs[lbfr_pkg::CFG_ROT_YY][15:0]));
        tx = longint'(signed'(regs[lbfr_pkg::CFG_SHIFT_X][15:0]));
        ty = longint'(signed'(regs[lbfr_pkg::CFG_SHIFT_Y][15:0]));
        beam_trig(amin + longint'(idx) * step, c, s);
        px = longint'(rng) * c;
        py = longint'(rng) * s;
        bx = fshr(rxx * px + rxy * py, 14) + tx * 16384;
        by = fshr(ryx * px + ryy * py, 14) + ty * 16384;
        bearing_of(bx, by, bear, mag);
        dmm = (mag * GAIN_L + (longint'(1) << 27)) >>> 28;
        if (dmm > 65535) dmm = 65535;
        e.dist_mm = dmm[15:0];
        bearing_of(rxx, ryx, yaw, ymag);
        if (step != 0) begin
          q = (bear - (amin + yaw)) / step;  // truncates toward zero
          if (q >= 0 && q < NBEAMS) begin
            e.hit = 1;
            e.bin = q[9:0];
          end
        end
      end
      pending.push_back(e);
    endfunction

    function void check_result(reproj_t got);
      reproj_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result bin=%0d dist=%0d hit=%0d",
                 $realtime, got.bin, got.dist_mm, got.hit);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.bin !== e.bin) begin
        $display("%0t: out_index expected %0d got %0d", $realtime, e.bin, got.bin);
        errors++;
      end
      if (got.dist_mm !== e.dist_mm) begin
        $display("%0t: out_range expected %0d got %0d", $realtime, e.dist_mm, got.dist_mm);
        errors++;
      end
      if (got.hit !== e.hit) begin
        $display("%0t: hit expected %0d got %0d", $realtime, e.hit, got.hit);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [9:0] beam_index, [25:10] beam_range
  logic        s_axis_tuser = 0;    // [0] range_finite
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [31:0] m_axis_tdata;        // [9:0] out_index, [25:10] out_range
  logic        m_axis_tuser;        // [0] hit
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  reproj_board board = new();
  bit hold_off = 0;      // long sink stall requested by the stimulus
  bit stim_done = 0;

  lidar_beam_frame_reprojection dut (.*);

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  // Beat scoreboard hooks: sample at the edge, before driver updates land.
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready)
      board.note_beam(s_axis_tdata[9:0], s_axis_tdata[25:10], s_axis_tuser);
    if (m_axis_tvalid && m_axis_tready)
      board.check_result('{bin: m_axis_tdata[9:0], dist_mm: m_axis_tdata[25:10],
                           hit: m_axis_tuser});
  end

  // Sink: random stalls per beat, bursts of always-ready, and one long hold-off.
  initial begin
    int gap;
    int mode;
    @(posedge rst_ni);
    forever begin
      if (hold_off) begin
        m_axis_tready <= 0;
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      mode = $urandom_range(0, 3);
      gap = (mode == 0) ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
        m_axis_tready <= 0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  task automatic write_cfg(lbfr_pkg::cfg_reg_e idx, logic [16:0] v);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    board.write_reg(idx, v);
    cfg_valid_i <= 0;
  endtask

  task automatic send_beam(logic [9:0] idx, logic [15:0] rng, logic fin, bit gaps);
    int gap;
    gap = (gaps && $urandom_range(0, 2) != 0) ? $urandom_range(0, 12) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {6'b0, rng, idx};
    s_axis_tuser <= fin;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic random_cfg(bit extreme);
    int a, b;
    write_cfg(lbfr_pkg::CFG_IN_ANGLE_MIN,
              extreme ? (($urandom_range(0, 1)) ? 17'(51472) : 17'(-51472))
                      : 17'($urandom_range(0, 102944) - 51472));
    write_cfg(lbfr_pkg::CFG_ANGLE_STEP, extreme ? 17'($urandom_range(0, 1) ? 16384 : 1)
                                                : 17'($urandom_range(1, 400)));
    // random rotation angle from a unit-ish matrix, sometimes arbitrary entries
    a = $urandom_range(0, 32768) - 16384;
    b = $urandom_range(0, 32768) - 16384;
    write_cfg(lbfr_pkg::CFG_ROT_XX, 17'(a));
    write_cfg(lbfr_pkg::CFG_ROT_XY, 17'(-b));
    write_cfg(lbfr_pkg::CFG_ROT_YX, 17'(b));
    write_cfg(lbfr_pkg::CFG_ROT_YY, extreme ? 17'(-16384) : 17'(a));
    write_cfg(lbfr_pkg::CFG_SHIFT_X, extreme ? 17'(16'h8000)
                                             : 17'($urandom_range(0, 4000) - 2000));
    write_cfg(lbfr_pkg::CFG_SHIFT_Y, extreme ? 17'(16'h7FFF) : 17'($urandom_range(0, 65535)));
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: field extremes at reset settings, a non-finite beam, origin vector.
    send_beam(10'd0, 16'd0, 1'b1, 0);
    send_beam(10'd1023, 16'hFFFF, 1'b1, 0);
    send_beam(10'd512, 16'd1000, 1'b0, 0);
    send_beam(10'd0, 16'hFFFF, 1'b1, 0);
    send_beam(10'd300, 16'd5000, 1'b1, 0);
    send_beam(10'h2AA, 16'h5555, 1'b1, 0);
    send_beam(10'h155, 16'hAAAA, 1'b1, 0);
    drain();
    // Negative start and a large step that maps beams only onto the lowest bins of the scan.
    write_cfg(lbfr_pkg::CFG_IN_ANGLE_MIN, 17'(-51472));
    write_cfg(lbfr_pkg::CFG_ANGLE_STEP, 17'd16384);
    write_cfg(lbfr_pkg::CFG_ROT_XX, 17'(-16384));
    write_cfg(lbfr_pkg::CFG_ROT_YY, 17'(-16384));
    write_cfg(lbfr_pkg::CFG_SHIFT_X, 17'(16'h7FFF));
    write_cfg(lbfr_pkg::CFG_SHIFT_Y, 17'(16'h8000));
    for (int i = 0; i < 6; i++) send_beam(10'(i * 200), 16'($urandom), 1'b1, 0);
    drain();
    // Zero step: no bin at all.
    write_cfg(lbfr_pkg::CFG_ANGLE_STEP, 17'd0);
    write_cfg(lbfr_pkg::CFG_ROT_XY, 17'd16384);
    write_cfg(lbfr_pkg::CFG_ROT_YX, 17'(-16384));
    for (int i = 0; i < 5; i++) send_beam(10'($urandom), 16'($urandom), 1'b1, 0);
    // Zero rotation with zero shift: every point at the origin.
    drain();
    write_cfg(lbfr_pkg::CFG_ANGLE_STEP, 17'd103);
    write_cfg(lbfr_pkg::CFG_ROT_XX, 17'd0);
    write_cfg(lbfr_pkg::CFG_ROT_XY, 17'd0);
    write_cfg(lbfr_pkg::CFG_ROT_YX, 17'd0);
    write_cfg(lbfr_pkg::CFG_ROT_YY, 17'd0);
    write_cfg(lbfr_pkg::CFG_SHIFT_X, 17'd0);
    write_cfg(lbfr_pkg::CFG_SHIFT_Y, 17'd0);
    for (int i = 0; i < 3; i++) send_beam(10'($urandom), 16'($urandom), 1'b1, 0);
    drain();

    // Random phases: each phase a new setting, then beams with random content.
    // The long sink stall gets more beats than the pipeline holds, so the input backs up.
    for (int ph = 0; ph < 9; ph++) begin
      random_cfg(ph % 4 == 3);
      if (ph == 2) hold_off = 1;   // sink stalls long while beams keep coming
      for (int n = 0; n < ((ph == 2) ? 120 : 40); n++)
        send_beam(10'($urandom), 16'($urandom), ($urandom_range(0, 7) != 0), ph != 2);
      drain();   // sender pauses until every result is back
    end
    stim_done = 1;
  end

  always @(posedge clk_i) begin
    if (stim_done) begin
      if (board.errors == 0 && board.pending.size() == 0)
        $display("tb_lidar_beam_frame_reprojection OK");
      else
        $display("tb_lidar_beam_frame_reprojection NOT OK");
      $finish;
    end
  end

  initial begin
    #2ms;
    $display("tb_lidar_beam_frame_reprojection NOT OK");
    $finish;
  end
endmodule

### filelist.f
sv/lbfr_pkg.sv
sv/lbfr_rotate.sv
sv/lbfr_vector.sv
sv/lbfr_divide.sv
sv/lidar_beam_frame_reprojection.sv
tb/tb_lidar_beam_frame_reprojection.sv
